// ===== hw/rtl/rc4_pkg.sv =====
// ============================================================================
// RC4 stream cipher package
// Shared types and constants for the RC4 cipher block and its S-box memory.
// ============================================================================
`default_nettype none

package rc4_pkg;

    // S-box geometry.
    localparam int SBOX_SIZE = 256;
    localparam int BYTE_W    = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    // Request type codes.
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic  req_type;
        byte_t in_byte;
        logic  is_last;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        byte_t out_byte;
        logic  key_done;
        logic  out_last;
    } out_item_t;

    // Access request from the sequencer to the S-box memory.
    typedef struct packed {
        logic  clr;
        logic  we;
        byte_t waddr;
        byte_t wdata;
        logic  re;
        byte_t raddr;
    } sbox_req_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD_A = 5'b00010,
        ST_RD_B = 5'b00100,
        ST_WR_A = 5'b01000,
        ST_WR_B = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rc4_stream_cipher_top.sv =====
// ============================================================================
// RC4 stream cipher top level
// Key loading, key schedule and keystream generation around one S-box memory.
// ============================================================================
// Usage: the input channel carries key bytes (req_type 0) and data bytes
// (req_type 1) as valid/ready transactions. Key bytes fill the key store;
// bytes past MAX_KEY_BYTES are dropped. The key byte flagged last starts
// the key schedule, which ends in one acknowledge transaction on the output
// channel (key_done set, out_byte zero).
// Each data byte produces one output transaction: the byte XOR the next
// keystream byte, with its last flag copied to out_last.
// Sequencing: a data byte is accepted in IDLE and then passes RD_B, WR_A
// and WR_B, which loads the output register; no new item is accepted
// until the sequencer is back in IDLE. The steps are the dependent S-box
// reads and the two swap writes on the memory's read and write ports. A
// non-last key byte is stored in IDLE. The key acknowledge is loaded into
// the output register in WR_B of the last step, after the schedule has
// stepped through all 256 entries with four S-box accesses per step.
// Reset restores the identity S-box at once, clears the key count, and sets
// x to 1 and y to 0. When the receiver stalls, the finished result waits in
// ============================================================================
// the output register; the block keeps working and holds only when a second
// result would need that register.
// ============================================================================
`default_nettype none

module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire rc4_pkg::in_item_t in_data,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      rc4_pkg::out_item_t out_data
);

    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    rc4_pkg::state_t    state_reg, state_next;
    logic               sched_reg, sched_next;
    rc4_pkg::byte_t     x_reg, x_next;
    rc4_pkg::byte_t     y_reg, y_next;
    rc4_pkg::byte_t     a_reg, a_next;
    rc4_pkg::byte_t     b_reg, b_next;
    rc4_pkg::byte_t     t_reg, t_next;
    rc4_pkg::byte_t     data_reg, data_next;
    logic               last_reg, last_next;
    logic [KIDX_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]   key_count_reg, key_count_next;
    logic               out_valid_reg, out_valid_next;
    rc4_pkg::out_item_t out_data_reg, out_data_next;

    rc4_pkg::byte_t     key_mem [MAX_KEY_BYTES];
    rc4_pkg::byte_t     kb_reg;
    logic               key_we;
    logic               key_re;

    rc4_pkg::sbox_req_t sreq;
    rc4_pkg::byte_t     s_rd;
    rc4_pkg::byte_t     y_new;
    rc4_pkg::byte_t     t_new;
    rc4_pkg::byte_t     ks_byte;
    logic [CNT_W-1:0]   k_inc;
    logic               accept;
    logic               out_free;
    logic               key_room;

    // S-box memory.
    rc4_sbox_ram u_sbox (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rdata (s_rd)
    );

    // Key store: written at the fill count, read at the schedule key index.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_count_reg[KIDX_W-1:0]] <= in_data.in_byte;
        end
        if (key_re)
        begin
            kb_reg <= key_mem[k_reg];
        end
    end

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign key_room = key_count_reg < CNT_W'(MAX_KEY_BYTES);
    assign k_inc    = CNT_W'(k_reg) + CNT_W'(1);
    assign y_new    = y_reg + s_rd + (sched_reg ? kb_reg : '0);
    assign t_new    = a_reg + s_rd;

    // Keystream byte, forwarding the two swap writes over the stale read.
    assign ks_byte = (t_reg == y_reg) ? a_reg :
                     (t_reg == x_reg) ? b_reg : s_rd;

    // Sequencer for key loading, key schedule steps and data bytes.
    always_comb
    begin
        state_next     = state_reg;
        sched_next     = sched_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        key_count_next = key_count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sreq           = '0;
        key_we         = 1'b0;
        key_re         = 1'b0;
        in_ready       = (state_reg == rc4_pkg::ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    data_next = in_data.in_byte;
                    last_next = in_data.is_last;
                    if (in_data.req_type == rc4_pkg::REQ_DATA)
                    begin
                        // Start a data byte with the read of S[x].
                        sched_next = 1'b0;
                        sreq.re    = 1'b1;
                        sreq.raddr = x_reg;
                        state_next = rc4_pkg::ST_RD_B;
                    end
                    else
                    begin
                        if (key_room)
                        begin
                            key_we         = 1'b1;
                            key_count_next = key_count_reg + CNT_W'(1);
                        end
                        if (in_data.is_last)
                        begin
                            // Restore identity and start the schedule at zero.
                            sched_next = 1'b1;
                            sreq.clr   = 1'b1;
                            x_next     = '0;
                            y_next     = '0;
                            k_next     = '0;
                            state_next = rc4_pkg::ST_RD_A;
                        end
                    end
                end
            end

            rc4_pkg::ST_RD_A:
            begin
                // Schedule step: read S[i] and the current key byte.
                sreq.re    = 1'b1;
                sreq.raddr = x_reg;
                key_re     = 1'b1;
                state_next = rc4_pkg::ST_RD_B;
            end

            rc4_pkg::ST_RD_B:
            begin
                // Advance the second index and read the entry it points to.
                a_next     = s_rd;
                y_next     = y_new;
                sreq.re    = 1'b1;
                sreq.raddr = y_new;
                state_next = rc4_pkg::ST_WR_A;
            end

            rc4_pkg::ST_WR_A:
            begin
                // First half of the swap; data bytes also fetch S[a + b].
                b_next     = s_rd;
                sreq.we    = 1'b1;
                sreq.waddr = x_reg;
                sreq.wdata = s_rd;
                if (!sched_reg)
                begin
                    sreq.re    = 1'b1;
                    sreq.raddr = t_new;
                    t_next     = t_new;
                end
                state_next = rc4_pkg::ST_WR_B;
            end

            rc4_pkg::ST_WR_B:
            begin
                // Second half of the swap, then step or finish.
                sreq.we    = 1'b1;
                sreq.waddr = y_reg;
                sreq.wdata = a_reg;
                if (sched_reg)
                begin
                    if (x_reg == 8'hFF)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{out_byte: '0, key_done: 1'b1,
                                               out_last: 1'b0};
                            x_next         = 8'd1;
                            y_next         = '0;
                            key_count_next = '0;
                            state_next     = rc4_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        x_next = x_reg + 8'd1;
                        if (k_inc >= key_count_reg)
                        begin
                            k_next = '0;
                        end
                        else
                        begin
                            k_next = k_inc[KIDX_W-1:0];
                        end
                        state_next = rc4_pkg::ST_RD_A;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: data_reg ^ ks_byte, key_done: 1'b0,
                                       out_last: last_reg};
                    x_next         = x_reg + 8'd1;
                    state_next     = rc4_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            sched_reg     <= 1'b0;
            x_reg         <= 8'd1;
            y_reg         <= '0;
            k_reg         <= '0;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sched_reg     <= sched_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            k_reg         <= k_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_sbox_ram.sv =====
// ============================================================================
// RC4 S-box memory
// 256 x 8 synchronous memory with one write and one registered read port.
// Per-entry valid bits make a cleared entry read back as its own index,
// so the identity permutation is restored by clearing the valid bits.
// ============================================================================
`default_nettype none

module rc4_sbox_ram (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rc4_pkg::sbox_req_t req,
    output      rc4_pkg::byte_t     rdata
);

    rc4_pkg::byte_t                    sbox_mem [rc4_pkg::SBOX_SIZE];
    logic [rc4_pkg::SBOX_SIZE-1:0]     vld_reg;
    rc4_pkg::byte_t                    rd_mem_reg;
    logic                              rd_vld_reg;
    rc4_pkg::byte_t                    rd_addr_reg;

    // Valid bits: cleared on reset and on a clear request, set by a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.clr)
        begin
            vld_reg <= '0;
        end
        else if (req.we)
        begin
            vld_reg[req.waddr] <= 1'b1;
        end
    end

    // Memory array write and registered read.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            sbox_mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_mem_reg  <= sbox_mem[req.raddr];
            rd_vld_reg  <= vld_reg[req.raddr];
            rd_addr_reg <= req.raddr;
        end
    end

    // An entry never written since the last clear holds its own index.
    assign rdata = rd_vld_reg ? rd_mem_reg : rd_addr_reg;

endmodule

`default_nettype wire
